[sv/nrn_pkg.sv]
package nrn_pkg;

  localparam int MAX_DIM_DEF  = 512;
  localparam int OUT_SIZE_DEF = 336;

  localparam int COORD_W   = 9;
  localparam int CFG_W     = 10;
  localparam int CFG_IDX_W = 1;
  localparam int CH_W      = 8;
  localparam int PIX_W     = 3 * CH_W;
  localparam int NORM_W    = 16;

  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 1'd1;

  // means and deviations in thousandths
  localparam longint MEAN_R = 485;
  localparam longint MEAN_G = 456;
  localparam longint MEAN_B = 406;
  localparam longint DEN_R  = 255 * 229;
  localparam longint DEN_G  = 255 * 224;
  localparam longint DEN_B  = 255 * 225;
  localparam longint Q_MAX  = 32767;
  localparam longint Q_MIN  = -32768;

  typedef enum logic [1:0] {
    CH_RED,
    CH_GREEN,
    CH_BLUE
  } chan_t;

  typedef logic [NORM_W-1:0] norm_tab_t [0:255];

  typedef struct packed {
    logic              op;
    logic              first;
    logic [CH_W-1:0]   red_in;
    logic [CH_W-1:0]   green_in;
    logic [CH_W-1:0]   blue_in;
    logic [COORD_W-1:0] out_col;
    logic [COORD_W-1:0] out_row;
  } in_word_t;

  typedef struct packed {
    logic signed [NORM_W-1:0] norm_red;
    logic signed [NORM_W-1:0] norm_green;
    logic signed [NORM_W-1:0] norm_blue;
    logic                     source_present;
  } out_word_t;

  // round(4096 * (v/255 - mean) / dev), ties away from zero, saturated
  function automatic norm_tab_t build_norm(input chan_t ch);
    norm_tab_t tab;
    longint    num;
    longint    q;
    int        v;
    for (v = 0; v < 256; v++) begin
      unique case (ch)
        CH_RED: begin
          num = 4096 * (longint'(v) * 1000 - 255 * MEAN_R);
          if (num >= 0) q = (num + DEN_R / 2) / DEN_R;
          else q = -((-num + DEN_R / 2) / DEN_R);
        end
        CH_GREEN: begin
          num = 4096 * (longint'(v) * 1000 - 255 * MEAN_G);
          if (num >= 0) q = (num + DEN_G / 2) / DEN_G;
          else q = -((-num + DEN_G / 2) / DEN_G);
        end
        CH_BLUE: begin
          num = 4096 * (longint'(v) * 1000 - 255 * MEAN_B);
          if (num >= 0) q = (num + DEN_B / 2) / DEN_B;
          else q = -((-num + DEN_B / 2) / DEN_B);
        end
        default: begin
          num = 0;
          q   = 0;
        end
      endcase
      if (q > Q_MAX) q = Q_MAX;
      if (q < Q_MIN) q = Q_MIN;
      tab[v] = NORM_W'(q);
    end
    return tab;
  endfunction

  localparam norm_tab_t NORM_RED   = build_norm(CH_RED);
  localparam norm_tab_t NORM_GREEN = build_norm(CH_GREEN);
  localparam norm_tab_t NORM_BLUE  = build_norm(CH_BLUE);

endpackage

[sv/nearest_resize_normalize.sv]
// Load word: taken at the accepting edge, busy stays low, the next word may follow at once.
// Read word: busy rises at the accepting edge and falls at the edge that raises the result
// strobe (done); no word is taken while busy is high, so a read ends before the next word.
// The read runs through the 4-stage reciprocal divide per axis, the index register,
// the store read and the output register.
// Sync reset clears busy, done, the write address, sets both sizes to 1; no store clear.
module nearest_resize_normalize
  import nrn_pkg::*;
#(
  parameter int MAX_DIM  = MAX_DIM_DEF,
  parameter int OUT_SIZE = OUT_SIZE_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  in_word_t             req,
  output logic                 done,
  output out_word_t            result,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int WAW   = $clog2(DEPTH + 1);
  localparam int SW    = $clog2(MAX_DIM + 1);
  localparam int XW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

  // configuration and fill state
  logic [CFG_W-1:0] src_width;
  logic [CFG_W-1:0] src_height;
  logic [WAW-1:0]   write_address;

  // clamp sizes: zero acts as one, above MAX_DIM acts as MAX_DIM
  logic [SW-1:0] eff_w;
  logic [SW-1:0] eff_h;

  always_comb begin
    if (src_width == '0) eff_w = SW'(1);
    else if (src_width > MAX_DIM) eff_w = SW'(MAX_DIM);
    else eff_w = SW'(src_width);
    if (src_height == '0) eff_h = SW'(1);
    else if (src_height > MAX_DIM) eff_h = SW'(MAX_DIM);
    else eff_h = SW'(src_height);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width  <= CFG_W'(1);
      src_height <= CFG_W'(1);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SRC_WIDTH:  src_width  <= cfg_data;
        REG_SRC_HEIGHT: src_height <= cfg_data;
      endcase
    end
  end

  // accept
  logic accept;
  logic load_acc;
  logic read_acc;

  assign accept   = start && !busy;
  assign load_acc = accept && !req.op;
  assign read_acc = accept && req.op;

  // load path: restart on first, saturate when the store is full
  logic [WAW-1:0] wr_base;
  logic           wr_ok;
  logic           st_we;

  assign wr_base = req.first ? '0 : write_address;
  assign wr_ok   = wr_base < WAW'(DEPTH);
  assign st_we   = load_acc && wr_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      write_address <= '0;
    end else if (st_we) begin
      write_address <= wr_base + WAW'(1);
    end
  end

  // nearest source column and row, one divide lane per axis
  logic          x_valid;
  logic          y_valid;
  logic [XW-1:0] near_x;
  logic [XW-1:0] near_y;

  nrn_map #(
    .MAX_DIM (MAX_DIM),
    .OUT_SIZE(OUT_SIZE)
  ) u_map_x (
    .clk      (clk),
    .rst      (rst),
    .in_valid (read_acc),
    .coord    (req.out_col),
    .size     (eff_w),
    .out_valid(x_valid),
    .near     (near_x)
  );

  nrn_map #(
    .MAX_DIM (MAX_DIM),
    .OUT_SIZE(OUT_SIZE)
  ) u_map_y (
    .clk      (clk),
    .rst      (rst),
    .in_valid (read_acc),
    .coord    (req.out_row),
    .size     (eff_h),
    .out_valid(y_valid),
    .near     (near_y)
  );

  // linear index y*w + x, then the store read and the presence check
  logic [XW+SW:0]   idx_full;
  logic [AW-1:0]    idx;
  logic             idx_valid;
  logic             rd_valid;
  logic             present;
  logic [PIX_W-1:0] rd_pix;
  logic [PIX_W-1:0] pix;

  assign idx_full = near_y * eff_w + (XW + SW + 1)'(near_x);

  always_ff @(posedge clk) begin
    if (rst) begin
      idx_valid <= 1'b0;
      rd_valid  <= 1'b0;
    end else begin
      idx_valid <= x_valid && y_valid;
      rd_valid  <= idx_valid;
    end
    idx     <= idx_full[AW-1:0];
    // no loads are taken during a read, so write_address holds here
    present <= WAW'(idx) < write_address;
  end

  nrn_store #(
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (st_we),
    .waddr(wr_base[AW-1:0]),
    .wdata({req.red_in, req.green_in, req.blue_in}),
    .re   (idx_valid),
    .raddr(idx),
    .rdata(rd_pix)
  );

  // drop the store word for a pixel never loaded: channels read as zero
  assign pix = present ? rd_pix : '0;

  // output register and busy control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= rd_valid;
      if (read_acc) begin
        busy <= 1'b1;
      end else if (rd_valid) begin
        busy <= 1'b0;
      end
    end
    if (rd_valid) begin
      result.norm_red       <= $signed(NORM_RED[pix[3*CH_W-1:2*CH_W]]);
      result.norm_green     <= $signed(NORM_GREEN[pix[2*CH_W-1:CH_W]]);
      result.norm_blue      <= $signed(NORM_BLUE[pix[CH_W-1:0]]);
      result.source_present <= present;
    end
  end

  // a result only ever ends a read that held busy
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a read in flight");

  // a read that is taken raises busy
  a_read_sets_busy: assert property (@(posedge clk) disable iff (rst)
    read_acc |=> busy)
    else $error("busy not raised after a read was taken");

  // the store is never written while a read is in flight
  a_no_write_in_read: assert property (@(posedge clk) disable iff (rst)
    st_we |-> !busy)
    else $error("store written during a read");

  // the fill count saturates at the store depth
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    write_address <= WAW'(DEPTH))
    else $error("write address beyond the store depth");

endmodule

[sv/nrn_map.sv]
module nrn_map
  import nrn_pkg::*;
#(
  parameter int MAX_DIM  = MAX_DIM_DEF,
  parameter int OUT_SIZE = OUT_SIZE_DEF,
  localparam int SW = $clog2(MAX_DIM + 1),
  localparam int XW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [COORD_W-1:0] coord,
  input  logic [SW-1:0]      size,
  output logic               out_valid,
  output logic [XW-1:0]      near
);

  localparam int PW = COORD_W + SW;
  localparam int OW = $clog2(OUT_SIZE + 1);
  localparam logic [PW:0] RECIP = (PW + 1)'((2 ** PW) / OUT_SIZE);

  logic [3:0]        vld;
  logic [PW-1:0]     prod;
  logic [PW-1:0]     prod2;
  logic [PW-1:0]     est;
  logic [PW-1:0]     quot;
  logic [2*PW:0]     m1;
  logic [PW+OW-1:0]  m2;
  logic [PW+OW-1:0]  rem;
  logic [SW-1:0]     lim;
  logic [SW-1:0]     sel;

  // reciprocal estimate is low by at most one; fix it with one compare
  assign m1  = prod * RECIP;
  assign m2  = est * OW'(OUT_SIZE);
  assign rem = (PW + OW)'(prod2) - m2;
  assign lim = size - SW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[2:0], in_valid};
    end
    prod  <= PW'(coord * size);
    est   <= m1[2*PW-1:PW];
    prod2 <= prod;
    quot  <= est + PW'(rem >= (PW + OW)'(OUT_SIZE));
    sel   <= (quot > PW'(lim)) ? lim : SW'(quot);
  end

  assign out_valid = vld[3];
  assign near      = sel[XW-1:0];

endmodule

[sv/nrn_store.sv]
module nrn_store
  import nrn_pkg::*;
#(
  parameter int DEPTH = MAX_DIM_DEF * MAX_DIM_DEF,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [PIX_W-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [PIX_W-1:0] rdata
);

  logic [PIX_W-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
